// ===== src/ebd_pkg.sv =====
package ebd_pkg;

	// request codes carried on the input kind field
	localparam logic [2:0] REQ_BIND       = 3'd0;
	localparam logic [2:0] REQ_UNBIND     = 3'd1;
	localparam logic [2:0] REQ_UNBIND_ALL = 3'd2;
	localparam logic [2:0] REQ_TRIGGER    = 3'd3;
	localparam logic [2:0] REQ_ACK        = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BOUND     = 2'd1;
	localparam logic [1:0] STAT_NOT_BOUND = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	// cap on deliveries made by one trigger
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = 5;

	// one binding held by a cell
	typedef struct packed {
		logic [7:0] task_id;
		logic [7:0] event_id;
		logic       armed;
	} entry_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ===== src/ebd_cell.sv =====
module ebd_cell
	import ebd_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    next_entry,
	input  entry_t    wr_entry,
	output entry_t    entry
);

	entry_t entry_q;

	// a write from the sequencer wins over the shift from the neighbor
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			entry_q <= wr_entry;
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

// ===== src/event_binding_dispatch_table_core.sv =====
// Event binding dispatch table.
// Input channel s_*: one request item per handshake; s_tuser carries the
// request kind, s_tdata the task and event ids. Output channel m_*: result
// items; m_tuser flags a delivery, m_tdata holds status and delivered task,
// m_tlast marks the final result of a request.
// The table is a row of TABLE_DEPTH cells. A request walks the occupied
// entries past the head cell, one entry a cycle unless the output stalls,
// while every cell hands its entry to the neighbor toward the head; kept
// entries are written back behind the unscanned ones, so removals keep
// table order. A request scans each occupied entry, then leaves the scan
// for a finish step that loads the final result; a new request is taken
// the cycle after the final result is loaded. The single output register
// stalls the scan and the finish while a result waits to be taken.
// Reset empties the table (fill count to zero) and drops any pending result;
// entry contents are never cleared and only entries below the count are read.
module event_binding_dispatch_table_core
	import ebd_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // task_id[7:0], event_id[15:8]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // status[1:0], dispatch_task[9:2], zero[15:10]
	output logic [0:0]  m_tuser,   // dispatch_valid[0]
	output logic        m_tlast
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     kept_q;
	logic                 found_q;
	logic                 pend_valid_q;
	logic [7:0]           pend_task_q;
	logic [RES_CNT_W-1:0] nres_q;

	logic [2:0] req_q;
	logic [7:0] task_q;
	logic [7:0] event_q;

	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic       out_dv_q;
	logic [7:0] out_task_q;
	logic       out_last_q;

	entry_t    cell_entry [TABLE_DEPTH];
	cell_ctl_t cell_ctl   [TABLE_DEPTH];
	entry_t    wr_entry;

	entry_t           head;
	entry_t           proc;
	logic             keep;
	logic             hit_pair;
	logic             hit_first;
	logic             fire;
	logic             step;
	logic             finish;
	logic             append;
	logic             can_emit;
	logic             emit;
	logic [1:0]       emit_status;
	logic             emit_dv;
	logic [7:0]       emit_task;
	logic             emit_last;
	logic [1:0]       fin_status;
	logic [CNT_W-1:0] wr_pos;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] app_idx;
	logic             accept;

	assign accept   = s_tvalid && s_tready;
	assign can_emit = !out_valid_q || m_tready;
	assign head     = cell_entry[0];

	// per-entry decision at the head cell
	always_comb begin
		hit_pair  = (head.task_id == task_q) && (head.event_id == event_q);
		hit_first = hit_pair && !found_q;
		proc      = head;
		keep      = 1'b1;
		fire      = 1'b0;
		case (req_q)
			REQ_UNBIND: begin
				keep = !hit_first;
			end
			REQ_UNBIND_ALL: begin
				keep = (head.task_id != task_q);
			end
			REQ_ACK: begin
				if (hit_first) begin
					proc.armed = 1'b1;
				end
			end
			REQ_TRIGGER: begin
				fire = (head.event_id == event_q) && head.armed &&
					(nres_q < RES_CNT_W'(MAX_RESULTS));
				if (fire) begin
					proc.armed = 1'b0;
				end
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	// status of the closing result
	always_comb begin
		fin_status = STAT_OK;
		append     = 1'b0;
		case (req_q)
			REQ_BIND: begin
				if (found_q) begin
					fin_status = STAT_BOUND;
				end else if (kept_q >= CNT_W'(TABLE_DEPTH)) begin
					fin_status = STAT_FULL;
				end else begin
					append = finish;
				end
			end
			REQ_UNBIND, REQ_ACK: begin
				fin_status = found_q ? STAT_OK : STAT_NOT_BOUND;
			end
			default: begin
				fin_status = STAT_OK;
			end
		endcase
	end

	// sequencer: next state, scan steps and result loads
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		step        = 1'b0;
		finish      = 1'b0;
		emit        = 1'b0;
		emit_status = STAT_OK;
		emit_dv     = 1'b0;
		emit_task   = 8'd0;
		emit_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rem_q == '0) begin
					state_d = ST_DONE;
				end else if (can_emit) begin
					step = 1'b1;
					if (fire && pend_valid_q) begin
						emit      = 1'b1;
						emit_dv   = 1'b1;
						emit_task = pend_task_q;
					end
				end
			end
			ST_DONE: begin
				if (can_emit) begin
					finish    = 1'b1;
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
					if (req_q == REQ_TRIGGER && pend_valid_q) begin
						emit_dv   = 1'b1;
						emit_task = pend_task_q;
					end else begin
						emit_status = fin_status;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// write-back slot sits just behind the unscanned entries
	assign wr_pos  = rem_q - CNT_W'(1) + kept_q;
	assign wr_idx  = wr_pos[IDX_W-1:0];
	assign app_idx = kept_q[IDX_W-1:0];

	always_comb begin
		if (append) begin
			wr_entry.task_id  = task_q;
			wr_entry.event_id = event_q;
			wr_entry.armed    = 1'b1;
		end else begin
			wr_entry = proc;
		end
	end

	// row of cells, each fed by the neighbor farther from the head (the tail cell by its own entry)
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t next_entry;
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign next_entry = cell_entry[i];
		end else begin : g_body
			assign next_entry = cell_entry[i+1];
		end
		assign cell_ctl[i].shift = step;
		assign cell_ctl[i].wr    = (step && keep && (wr_idx == IDX_W'(i))) ||
			(append && (app_idx == IDX_W'(i)));
		ebd_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.next_entry (next_entry),
			.wr_entry   (wr_entry),
			.entry      (cell_entry[i])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rem_q        <= '0;
			kept_q       <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			nres_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rem_q        <= count_q;
				kept_q       <= '0;
				found_q      <= 1'b0;
				pend_valid_q <= 1'b0;
				nres_q       <= '0;
			end
			if (step) begin
				rem_q  <= rem_q - CNT_W'(1);
				kept_q <= kept_q + CNT_W'(keep);
				if (hit_pair) begin
					found_q <= 1'b1;
				end
				if (fire) begin
					pend_valid_q <= 1'b1;
					nres_q       <= nres_q + RES_CNT_W'(1);
				end
			end
			if (finish) begin
				count_q <= append ? kept_q + CNT_W'(1) : kept_q;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= s_tuser;
			task_q  <= s_tdata[7:0];
			event_q <= s_tdata[15:8];
		end
		if (step && fire) begin
			pend_task_q <= head.task_id;
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_dv_q     <= emit_dv;
			out_task_q   <= emit_task;
			out_last_q   <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_task_q, out_status_q};
	assign m_tuser  = out_dv_q;
	assign m_tlast  = out_last_q;

	// fill count stays within the row of cells
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// unscanned plus kept entries never exceed the table in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, rem_q} + {1'b0, kept_q} <= {1'b0, count_q}))
		else $error("scan bookkeeping out of range");

	// a trigger never delivers more than the cap
	assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("too many deliveries");

	// a delivery is always reported with success status
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_dv_q) |-> (out_status_q == STAT_OK))
		else $error("delivery with failure status");

	// the table only changes size at the close of a request
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DONE) |=> $stable(count_q))
		else $error("entry count changed mid-request");

endmodule
